// ===== design/wdt_pkg.sv =====
// ============================================================================
// wdt_pkg: shared types and constants of the task watchdog
// Item kinds, health and policy codes, the monitor record kept in memory and
// the reply record carried to the result channel.
// ============================================================================
`default_nettype none

package wdt_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_FEED  = 2'd1,
    MODE_ADD   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  // Monitor health codes.
  typedef enum logic [1:0] {
    HLTH_HEALTHY  = 2'd0,
    HLTH_WARNING  = 2'd1,
    HLTH_CRITICAL = 2'd2,
    HLTH_PENDING  = 2'd3
  } health_t;

  // Action taken when a monitor reaches its fail limit.
  typedef enum logic [1:0] {
    POL_NONE      = 2'd0,
    POL_REINIT    = 2'd1,
    POL_SYSTEM    = 2'd2,
    POL_NO_ACTION = 2'd3
  } policy_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_MODIFY = 2'd2,
    ST_REPLY  = 2'd3
  } state_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_ARMED    = 1'b1;

  // Interval used when the check interval register holds zero.
  localparam logic [15:0] FALLBACK_INTERVAL = 16'd1000;
  localparam logic [7:0]  FAIL_MAX          = 8'd255;

  // One monitor as stored in the table memory.
  typedef struct packed {
    logic        fed;
    logic [15:0] timeout;
    logic [16:0] idle;
    logic [7:0]  fail_cnt;
    logic [7:0]  fail_lim;
    health_t     health;
    policy_t     policy;
  } mon_rec_t;

  localparam int REC_W = $bits(mon_rec_t);

  // Side effects of checking one monitor.
  typedef struct packed {
    logic reinit;
    logic stop;
  } eval_flags_t;

  // One reply beat.
  typedef struct packed {
    logic        add_ok;
    logic [2:0]  new_index;
    health_t     queried_state;
    logic        check_done;
    logic [7:0]  reinit_mask;
    logic        reboot_req;
    logic [2:0]  reset_monitor;
  } result_t;

endpackage

`default_nettype wire

// ===== design/wdt_mem.sv =====
// ============================================================================
// wdt_mem: monitor table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module wdt_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int W     = 54
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/wdt_eval.sv =====
// ============================================================================
// wdt_eval: health check of one monitor
// Takes one stored monitor record and returns the record after a check
// interval has passed, together with the reinit and system reset flags.
// ============================================================================
`default_nettype none

module wdt_eval (
  input  wdt_pkg::mon_rec_t    rec_i,
  input  logic [15:0]          interval,
  input  logic                 armed,
  output wdt_pkg::mon_rec_t    rec_o,
  output wdt_pkg::eval_flags_t flags
);

  import wdt_pkg::*;

  logic [16:0] idle_sum;
  logic [7:0]  fail_inc;

  // Idle time wraps at 17 bits; the failure count saturates.
  assign idle_sum = rec_i.idle + {1'b0, interval};
  assign fail_inc = (rec_i.fail_cnt == FAIL_MAX) ? rec_i.fail_cnt : rec_i.fail_cnt + 8'd1;

  always_comb begin
    rec_o = rec_i;
    flags = '0;
    if (rec_i.fed) begin
      // A fed monitor starts over as healthy.
      rec_o.fed      = 1'b0;
      rec_o.idle     = '0;
      rec_o.fail_cnt = '0;
      rec_o.health   = HLTH_HEALTHY;
    end else if (idle_sum < {1'b0, rec_i.timeout}) begin
      rec_o.idle = idle_sum;
    end else begin
      // Timeout: count a failure and apply the policy at the limit.
      rec_o.idle     = '0;
      rec_o.fail_cnt = fail_inc;
      if (fail_inc >= rec_i.fail_lim) begin
        case (rec_i.policy)
          POL_NONE: begin
            rec_o.health = HLTH_CRITICAL;
          end
          POL_REINIT: begin
            rec_o.health   = HLTH_WARNING;
            rec_o.fail_cnt = '0;
            flags.reinit   = 1'b1;
          end
          POL_SYSTEM: begin
            rec_o.health = HLTH_PENDING;
            flags.stop   = armed;
          end
          default: begin
            rec_o.health = HLTH_PENDING;
          end
        endcase
      end else begin
        rec_o.health = HLTH_WARNING;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/multi_channel_task_watchdog_unit.sv =====
// ============================================================================
// multi_channel_task_watchdog_unit: table of task monitors
// Registers monitors, takes feeds and queries, and checks the registered
// monitors once per check interval of 1 ms ticks, up to an armed reset.
// ============================================================================
// Usage:
//   Input beats (valid/ready) carry a tick, a feed, an add or a query. Every
//   input beat produces exactly one reply beat (valid/ready), in order.
//   Monitor records live in a synchronous RAM and are updated by
//   read-modify-write; adds take slots in order, so the fill count tells
//   which entries hold data.
//   Items that need no table read go from the input beat straight to the
//   reply state; a feed or query of an active monitor passes through the
//   read and modify states first, and a tick that runs a health check reads
//   the first entry and stays in the modify state until the walk ends at the
//   last active monitor or at an armed reset request. The check walks the
//   table one entry per cycle through the RAM read port while writing back
//   the previous entry. The next beat is taken once the block is idle again.
//   One item is in work at a time; the next beat is taken as soon as the
//   reply has moved to the output register, even when the receiver stalls.
//   A stalled receiver holds the reply; the block then finishes the next
//   item and waits for the output register to free up.
//   Synchronous reset empties the table, clears the tick counter, sets the
//   check interval to 1000 and disarms system reset.
// ============================================================================
`default_nettype none

module multi_channel_task_watchdog_unit #(
  parameter int MONITORS           = 8,
  parameter int DEFAULT_TIMEOUT    = 1000,
  parameter int DEFAULT_FAIL_LIMIT = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [7:0]                     in_monitor_index,
  input  logic [15:0]                    in_timeout,
  input  logic [7:0]                     in_fail_limit,
  input  logic [1:0]                     in_reset_policy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_add_ok,
  output logic [2:0]                     out_new_index,
  output logic [1:0]                     out_queried_state,
  output logic                           out_check_done,
  output logic [7:0]                     out_reinit_mask,
  output logic                           out_reboot_req,
  output logic [2:0]                     out_reset_monitor,
  input  logic                           cfg_we,
  input  logic [wdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdt_pkg::CFG_DATA_W-1:0] cfg_data
);

  import wdt_pkg::*;

  localparam int AW = (MONITORS > 1) ? $clog2(MONITORS) : 1;
  localparam int CW = $clog2(MONITORS + 1);

  // Control and configuration registers.
  state_t        state_r, state_nxt;
  logic [15:0]   interval_r;
  logic          armed_r;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Item in work and reply registers.
  mode_t         mode_r, mode_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  result_t       res_r, res_nxt;
  result_t       out_r;
  logic          out_load;

  // Table memory ports.
  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  mon_rec_t          mem_wr_data;
  logic [REC_W-1:0]  mem_rd_raw;
  mon_rec_t          rd_rec, eval_rec, add_rec;
  eval_flags_t       eval_flags;

  // Helpers.
  logic [15:0] interval_eff;
  logic [15:0] elapsed_inc;
  logic        idx_valid, idx_active, walk_last;

  wdt_mem #(
    .DEPTH (MONITORS),
    .AW    (AW),
    .W     (REC_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_raw)
  );

  assign rd_rec = mon_rec_t'(mem_rd_raw);

  wdt_eval u_eval (
    .rec_i    (rd_rec),
    .interval (interval_eff),
    .armed    (armed_r),
    .rec_o    (eval_rec),
    .flags    (eval_flags)
  );

  // A zero check interval acts as the fallback interval.
  assign interval_eff = (interval_r == '0) ? FALLBACK_INTERVAL : interval_r;
  assign elapsed_inc  = elapsed_r + 16'd1;
  assign idx_valid    = in_monitor_index < 8'(MONITORS);
  assign idx_active   = in_monitor_index < 8'(count_r);
  assign walk_last    = (CW'(addr_r) + CW'(1)) == count_r;

  // Record written for a new monitor; zero fields pick their defaults.
  always_comb begin
    add_rec          = '0;
    add_rec.timeout  = (in_timeout != '0) ? in_timeout : 16'(DEFAULT_TIMEOUT);
    add_rec.fail_lim = (in_fail_limit != '0) ? in_fail_limit : 8'(DEFAULT_FAIL_LIMIT);
    add_rec.health   = HLTH_HEALTHY;
    add_rec.policy   = policy_t'(in_reset_policy);
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer: next state, memory control and register updates.
  always_comb begin
    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    mode_nxt    = mode_r;
    addr_nxt    = addr_r;
    res_nxt     = res_r;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = eval_rec;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = mode_t'(in_mode);
          addr_nxt  = in_monitor_index[AW-1:0];
          res_nxt   = '0;
          state_nxt = ST_REPLY;
          case (mode_t'(in_mode))
            MODE_TICK: begin
              if (elapsed_inc >= interval_eff) begin
                elapsed_nxt        = '0;
                res_nxt.check_done = 1'b1;
                addr_nxt           = '0;
                if (count_r != '0) begin
                  state_nxt = ST_READ;
                end
              end else begin
                elapsed_nxt = elapsed_inc;
              end
            end
            MODE_FEED: begin
              if (idx_valid && idx_active) begin
                state_nxt = ST_READ;
              end
            end
            MODE_ADD: begin
              if (count_r < CW'(MONITORS)) begin
                mem_wr_en         = 1'b1;
                mem_wr_addr       = count_r[AW-1:0];
                mem_wr_data       = add_rec;
                count_nxt         = count_r + CW'(1);
                res_nxt.add_ok    = 1'b1;
                res_nxt.new_index = 3'(count_r);
              end
            end
            MODE_QUERY: begin
              if (!idx_valid) begin
                res_nxt.queried_state = HLTH_CRITICAL;
              end else if (idx_active) begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_REPLY;
            end
          endcase
        end
      end

      ST_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = addr_r;
        state_nxt   = ST_MODIFY;
      end

      ST_MODIFY: begin
        state_nxt = ST_REPLY;
        case (mode_r)
          MODE_TICK: begin
            // Write back this entry and, unless the walk ends here, fetch the next one in the same cycle.
            mem_wr_en   = 1'b1;
            mem_wr_data = eval_rec;
            if (eval_flags.reinit) begin
              res_nxt.reinit_mask = res_r.reinit_mask | (8'd1 << addr_r);
            end
            if (eval_flags.stop) begin
              res_nxt.reboot_req    = 1'b1;
              res_nxt.reset_monitor = 3'(addr_r);
            end else if (!walk_last) begin
              addr_nxt    = addr_r + AW'(1);
              mem_rd_en   = 1'b1;
              mem_rd_addr = addr_r + AW'(1);
              state_nxt   = ST_MODIFY;
            end
          end
          MODE_FEED: begin
            mem_wr_en       = 1'b1;
            mem_wr_data     = rd_rec;
            mem_wr_data.fed = 1'b1;
          end
          MODE_QUERY: begin
            res_nxt.queried_state = rd_rec.health;
          end
          default: begin
            state_nxt = ST_REPLY;
          end
        endcase
      end

      ST_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= FALLBACK_INTERVAL;
      armed_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_INTERVAL: interval_r <= cfg_data;
        REG_RESET_ARMED:    armed_r    <= cfg_data[0];
        default:            armed_r    <= armed_r;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // Reply channel.
  assign out_valid         = out_valid_r;
  assign out_add_ok        = out_r.add_ok;
  assign out_new_index     = out_r.new_index;
  assign out_queried_state = out_r.queried_state;
  assign out_check_done    = out_r.check_done;
  assign out_reinit_mask   = out_r.reinit_mask;
  assign out_reboot_req    = out_r.reboot_req;
  assign out_reset_monitor = out_r.reset_monitor;

  // The walk never reads the entry it is writing back.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
    else $error("table read and write hit the same entry");

  // Only one item is in work at a time.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A system reset request only comes out of a health check.
  a_reset_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reboot_req |-> out_check_done)
    else $error("system reset reported outside a health check");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MONITORS))
    else $error("monitor count beyond table size");

endmodule

`default_nettype wire

// ===== tb/multi_channel_task_watchdog_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multi_channel_task_watchdog_unit_tb: self-checking bench of the task watchdog
// A short table of hand-picked beats covers reset state, every item kind, the
// full table and out-of-range indices. Phases of random ticks, feeds, queries
// and adds follow under several check intervals and arming settings. A
// behavioral mirror of the monitor table predicts the replies of untyped beats,
// typed rows give their own, and replies are compared field by field in order.
// ============================================================================

module multi_channel_task_watchdog_unit_tb;
  import wdt_pkg::*;

  localparam int NUM_MON      = 8;
  localparam int DEF_TIMEOUT  = 1000;
  localparam int DEF_FAIL_LIM = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // Random phases: configuration, length and item mix of each.
  localparam int NUM_PHASES = 8;
  localparam int PH_INTERVAL [NUM_PHASES] = '{1, 65535, 1, 0, 3, 1, 2, 1};
  localparam int PH_ARMED    [NUM_PHASES] = '{0, 1, 1, 0, 0, 0, 1, 0};
  localparam int PH_ITEMS    [NUM_PHASES] = '{130, 80, 130, 80, 100, 160, 90, 80};
  localparam int PH_TICK     [NUM_PHASES] = '{60, 50, 60, 50, 60, 85, 60, 55};
  localparam int PH_FEED     [NUM_PHASES] = '{20, 25, 20, 25, 20, 8, 20, 25};
  localparam int PH_STARVE   [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 0};
  localparam int PH_HOLD     [NUM_PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0};

  // One input beat.
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  index;
    logic [15:0] timeout;
    logic [7:0]  fail_limit;
    policy_t     policy;
  } cmd_t;

  // One row of the directed table.
  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t want;
  } row_t;

  // Mirror of one monitor slot.
  typedef struct {
    bit          active;
    bit          fed;
    logic [15:0] timeout;
    logic [16:0] idle;
    logic [7:0]  fails;
    logic [7:0]  limit;
    health_t     health;
    policy_t     policy;
  } slot_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode         = '0;
  logic [7:0]  in_monitor_index = '0;
  logic [15:0] in_timeout      = '0;
  logic [7:0]  in_fail_limit   = '0;
  logic [1:0]  in_reset_policy = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_add_ok;
  logic [2:0]  out_new_index;
  logic [1:0]  out_queried_state;
  logic        out_check_done;
  logic [7:0]  out_reinit_mask;
  logic        out_reboot_req;
  logic [2:0]  out_reset_monitor;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Mirror of the block's state and configuration.
  logic [15:0] mir_interval = 16'd1000;
  logic        mir_armed    = 1'b0;
  logic [15:0] mir_ms       = '0;
  int unsigned mir_fill     = 0;
  slot_t       mir_slots [NUM_MON];

  result_t     replies_due [$];
  int unsigned n_errors     = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;

  // Receiver hold-off requests from the sender, served by the sink process.
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  logic [31:0] rx_cycle    = '0;

  multi_channel_task_watchdog_unit #(
    .MONITORS          (NUM_MON),
    .DEFAULT_TIMEOUT   (DEF_TIMEOUT),
    .DEFAULT_FAIL_LIMIT(DEF_FAIL_LIM)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_monitor_index (in_monitor_index),
    .in_timeout       (in_timeout),
    .in_fail_limit    (in_fail_limit),
    .in_reset_policy  (in_reset_policy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_add_ok       (out_add_ok),
    .out_new_index    (out_new_index),
    .out_queried_state(out_queried_state),
    .out_check_done   (out_check_done),
    .out_reinit_mask  (out_reinit_mask),
    .out_reboot_req   (out_reboot_req),
    .out_reset_monitor(out_reset_monitor),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mirror by one accepted beat and return the reply it causes.
  function automatic result_t predict_reply(cmd_t c);
    result_t     r;
    logic [15:0] iv;
    bit          stop;
    r    = '0;
    stop = 1'b0;
    iv   = (mir_interval == 16'd0) ? FALLBACK_INTERVAL : mir_interval;
    case (c.mode)
      MODE_TICK: begin
        mir_ms = mir_ms + 16'd1;
        if (mir_ms >= iv) begin
          mir_ms = '0;
          r.check_done = 1'b1;
          // Walk the active monitors in index order.
          for (int i = 0; i < NUM_MON; i++) begin
            if (!stop && i < mir_fill && mir_slots[i].active) begin
              if (mir_slots[i].fed) begin
                mir_slots[i].fed    = 1'b0;
                mir_slots[i].idle   = '0;
                mir_slots[i].fails  = '0;
                mir_slots[i].health = HLTH_HEALTHY;
              end else begin
                mir_slots[i].idle = mir_slots[i].idle + 17'(iv);
                if (mir_slots[i].idle >= {1'b0, mir_slots[i].timeout}) begin
                  if (mir_slots[i].fails != FAIL_MAX) begin
                    mir_slots[i].fails = mir_slots[i].fails + 8'd1;
                  end
                  mir_slots[i].idle = '0;
                  if (mir_slots[i].fails >= mir_slots[i].limit) begin
                    mir_slots[i].health = HLTH_PENDING;
                    case (mir_slots[i].policy)
                      POL_NONE: mir_slots[i].health = HLTH_CRITICAL;
                      POL_REINIT: begin
                        r.reinit_mask[i]    = 1'b1;
                        mir_slots[i].fails  = '0;
                        mir_slots[i].health = HLTH_WARNING;
                      end
                      POL_SYSTEM: begin
                        // An armed system reset ends the walk at this monitor.
                        if (mir_armed) begin
                          r.reboot_req    = 1'b1;
                          r.reset_monitor = 3'(i);
                          stop = 1'b1;
                        end
                      end
                      default: ;
                    endcase
                  end else begin
                    mir_slots[i].health = HLTH_WARNING;
                  end
                end
              end
            end
          end
        end
      end
      MODE_FEED: begin
        if (c.index < NUM_MON && mir_slots[c.index].active) begin
          mir_slots[c.index].fed = 1'b1;
        end
      end
      MODE_ADD: begin
        if (mir_fill < NUM_MON) begin
          mir_slots[mir_fill].active  = 1'b1;
          mir_slots[mir_fill].fed     = 1'b0;
          mir_slots[mir_fill].timeout = (c.timeout != 16'd0) ? c.timeout : 16'(DEF_TIMEOUT);
          mir_slots[mir_fill].idle    = '0;
          mir_slots[mir_fill].fails   = '0;
          mir_slots[mir_fill].limit   =
            (c.fail_limit != 8'd0) ? c.fail_limit : 8'(DEF_FAIL_LIM);
          mir_slots[mir_fill].health  = HLTH_HEALTHY;
          mir_slots[mir_fill].policy  = c.policy;
          r.add_ok    = 1'b1;
          r.new_index = 3'(mir_fill);
          mir_fill    = mir_fill + 1;
        end
      end
      MODE_QUERY: begin
        if (c.index < NUM_MON) begin
          r.queried_state = mir_slots[c.index].health;
        end else begin
          r.queried_state = HLTH_CRITICAL;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Build a directed row; the typed reply only carries add and query fields.
  function automatic row_t step_row(mode_t m, logic [7:0] idx, logic [15:0] tmo,
                                    logic [7:0] lim, policy_t pol, bit typed,
                                    logic ok, logic [2:0] nidx, health_t st);
    row_t row;
    row.cmd.mode       = m;
    row.cmd.index      = idx;
    row.cmd.timeout    = tmo;
    row.cmd.fail_limit = lim;
    row.cmd.policy     = pol;
    row.typed          = typed;
    row.want           = '0;
    row.want.add_ok        = ok;
    row.want.new_index     = nidx;
    row.want.queried_state = st;
    return row;
  endfunction

  // Offer one beat after an optional burst gap, then wait for acceptance.
  task automatic offer_item(input cmd_t c, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(30, 1);
      gap = ($urandom_range(4) == 0) ? $urandom_range(16, 4) : $urandom_range(3, 1);
    end
    burst_left = burst_left - 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= c.mode;
    in_monitor_index <= c.index;
    in_timeout       <= c.timeout;
    in_fail_limit    <= c.fail_limit;
    in_reset_policy  <= c.policy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_reply(c);
    replies_due.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait until every expected reply has arrived.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then random phases under changing settings.
  initial begin : stimulus
    cmd_t        c;
    row_t        tab [$];
    int unsigned pick;
    for (int i = 0; i < NUM_MON; i++) begin
      mir_slots[i].active  = 1'b0;
      mir_slots[i].fed     = 1'b0;
      mir_slots[i].timeout = '0;
      mir_slots[i].idle    = '0;
      mir_slots[i].fails   = '0;
      mir_slots[i].limit   = '0;
      mir_slots[i].health  = HLTH_HEALTHY;
      mir_slots[i].policy  = POL_NONE;
    end

    // Reset state, out-of-range indices, the eight adds and the full table.
    tab.push_back(step_row(MODE_QUERY, 8'd0, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_QUERY, 8'd255, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_CRITICAL));
    tab.push_back(step_row(MODE_QUERY, 8'd8, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_CRITICAL));
    tab.push_back(step_row(MODE_FEED, 8'd0, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_TICK, 8'd0, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd1, 8'd2, POL_NONE, 1, 1, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd2, 8'd0, POL_REINIT, 1, 1, 1, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_QUERY, 8'd1, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'hFFFF, 8'hFF, POL_NO_ACTION, 1, 1, 2,
                           HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd3, 8'd1, POL_SYSTEM, 1, 1, 3, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd0, 8'd0, POL_NONE, 1, 1, 4, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd1, 8'd1, POL_NO_ACTION, 1, 1, 5, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd4, 8'd2, POL_SYSTEM, 1, 1, 6, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'd1, 8'd1, POL_REINIT, 1, 1, 7, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_ADD, 8'd0, 16'hFFFF, 8'hFF, POL_NO_ACTION, 1, 0, 0,
                           HLTH_HEALTHY));
    tab.push_back(step_row(MODE_FEED, 8'd255, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_FEED, 8'd7, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_QUERY, 8'd7, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_HEALTHY));
    tab.push_back(step_row(MODE_QUERY, 8'd128, 16'd0, 8'd0, POL_NONE, 1, 0, 0, HLTH_CRITICAL));
    tab.push_back(step_row(MODE_TICK, 8'd255, 16'hFFFF, 8'hFF, POL_NO_ACTION, 0, 0, 0,
                           HLTH_HEALTHY));
    tab.push_back(step_row(MODE_FEED, 8'd6, 16'd0, 8'd0, POL_NONE, 0, 0, 0, HLTH_HEALTHY));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tab[k]) offer_item(tab[k].cmd, tab[k].typed, tab[k].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Settings change only while nothing is in flight.
      drain_replies();
      cfg_we    <= 1'b1;
      cfg_index <= REG_CHECK_INTERVAL;
      cfg_data  <= CFG_DATA_W'(PH_INTERVAL[p]);
      @(posedge clk);
      mir_interval = 16'(PH_INTERVAL[p]);
      cfg_index <= REG_RESET_ARMED;
      cfg_data  <= CFG_DATA_W'(PH_ARMED[p]);
      @(posedge clk);
      mir_armed = PH_ARMED[p][0];
      cfg_we <= 1'b0;

      for (int n = 0; n < PH_ITEMS[p]; n++) begin
        // Ask the sink for a long hold-off while beats keep coming.
        if (PH_HOLD[p] != 0 && n == 40) holds_asked <= holds_asked + 1;
        c.index      = 8'($urandom);
        c.timeout    = 16'($urandom);
        c.fail_limit = 8'($urandom);
        c.policy     = policy_t'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < PH_TICK[p]) begin
          c.mode = MODE_TICK;
        end else if (pick < PH_TICK[p] + PH_FEED[p]) begin
          // Monitor 0 goes unfed in most phases so its fail count saturates.
          c.mode = MODE_FEED;
          if ($urandom_range(9) != 0) c.index = 8'($urandom_range(NUM_MON - 1, PH_STARVE[p]));
        end else if (pick < 96) begin
          c.mode = MODE_QUERY;
          if ($urandom_range(6) != 0) c.index = 8'($urandom_range(NUM_MON - 1));
        end else begin
          c.mode = MODE_ADD;
        end
        offer_item(c, 1'b0, '0);
      end
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("** multi_channel_task_watchdog_unit: PASSED **");
    end else begin
      $display("** multi_channel_task_watchdog_unit: FAILED **");
    end
    $finish;
  end

  // Sink: long hold-offs on request, otherwise a rotating stall pattern.
  always @(posedge clk) begin : sink_pace
    rx_cycle <= rx_cycle + 32'd1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      case (rx_cycle[7:6])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(3) != 0);
        2'd2:    out_ready <= ($urandom_range(9) < 3);
        default: out_ready <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // Compare every reply beat with the oldest expected reply.
  always @(posedge clk) begin : reply_check
    result_t due;
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.add_ok        = out_add_ok;
      got.new_index     = out_new_index;
      got.queried_state = health_t'(out_queried_state);
      got.check_done    = out_check_done;
      got.reinit_mask   = out_reinit_mask;
      got.reboot_req    = out_reboot_req;
      got.reset_monitor = out_reset_monitor;
      if (replies_due.size() == 0) begin
        n_errors = n_errors + 1;
        if (n_errors <= MAX_REPORTS) begin
          $display("[%0t] reply beat arrived with none expected", $time);
        end
      end else begin
        due = replies_due.pop_front();
        if (got.add_ok !== due.add_ok || got.new_index !== due.new_index ||
            got.queried_state !== due.queried_state ||
            got.check_done !== due.check_done || got.reinit_mask !== due.reinit_mask ||
            got.reboot_req !== due.reboot_req ||
            got.reset_monitor !== due.reset_monitor) begin
          n_errors = n_errors + 1;
          if (n_errors <= MAX_REPORTS) begin
            $display("[%0t] reply mismatch (expected/actual): add_ok %0b/%0b idx %0d/%0d",
                     $time, due.add_ok, got.add_ok, due.new_index, got.new_index);
            $display("  state %0d/%0d check %0b/%0b reinit %02h/%02h sysrst %0b/%0b mon %0d/%0d",
                     due.queried_state, got.queried_state, due.check_done,
                     got.check_done, due.reinit_mask, got.reinit_mask,
                     due.reboot_req, got.reboot_req, due.reset_monitor,
                     got.reset_monitor);
          end
        end
      end
    end
  end

  // End the run when no beat or write has moved for too long.
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** multi_channel_task_watchdog_unit: FAILED **");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/wdt_pkg.sv
design/wdt_mem.sv
design/wdt_eval.sv
design/multi_channel_task_watchdog_unit.sv
tb/multi_channel_task_watchdog_unit_tb.sv
